>>> hw/rtl/dss_pkg.sv
// Shared types for the drive safety supervisor: mode, authority and event codes,
// the per-transfer decision record, and the legal-pair check.
// No dependencies.
`timescale 1ns / 1ps

package dss_pkg;

   typedef enum logic [2:0] {
      MODE_RESET_SAFE = 3'd0,
      MODE_DIAGNOSTIC = 3'd1,
      MODE_READY      = 3'd2,
      MODE_ALIGN      = 3'd3,
      MODE_RUN        = 3'd4,
      MODE_FAULT      = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      AUTH_NONE   = 2'd0,
      AUTH_DIAG   = 2'd1,
      AUTH_MOTION = 2'd2
   } auth_type;

   typedef enum logic [3:0] {
      EV_FAULT      = 4'd0,
      EV_INIT_DONE  = 4'd1,
      EV_READY_LOST = 4'd2,
      EV_READY_OK   = 4'd3,
      EV_DIAG_REQ   = 4'd4,
      EV_ALIGN_REQ  = 4'd5,
      EV_RUN_REQ    = 4'd6,
      EV_ALIGN_DONE = 4'd7,
      EV_RELEASE    = 4'd8,
      EV_FAULT_ACK  = 4'd9
   } ev_type;

   // Decision for one event: verdict, next state and derived flags.
   typedef struct packed {
      logic     accepted;
      mode_type mode_next;
      auth_type auth_next;
      logic     bridge_enable;
      logic     foreground_allowed;
   } step_type;

   function automatic logic pair_legal(input mode_type m, input auth_type a);
      logic ok;
      case (m)
         MODE_RESET_SAFE, MODE_DIAGNOSTIC, MODE_READY, MODE_FAULT: ok = (a == AUTH_NONE);
         MODE_ALIGN: ok = (a == AUTH_MOTION);
         MODE_RUN:   ok = (a == AUTH_DIAG) || (a == AUTH_MOTION);
         default:    ok = 1'b0;
      endcase
      return ok;
   endfunction

endpackage

>>> hw/rtl/dss_decide.sv
// Next-state and flag logic of the safety supervisor, purely combinational.
// Depends on dss_pkg.
`timescale 1ns / 1ps

module dss_decide (
   input  dss_pkg::mode_type mode,
   input  dss_pkg::auth_type auth,
   input  logic [3:0]        event_code,
   input  logic              energize_ok,
   input  logic              recover_ok,
   output dss_pkg::step_type step
);

   dss_pkg::ev_type   ev;
   dss_pkg::mode_type m_nx;
   dss_pkg::auth_type a_nx;
   logic              acc;
   logic              legal_nx;

   assign ev = dss_pkg::ev_type'(event_code);

   always_comb begin
      m_nx = mode;
      a_nx = auth;
      acc  = 1'b0;
      if (!dss_pkg::pair_legal(mode, auth)) begin
         // corrupted state: force fault, reject
         m_nx = dss_pkg::MODE_FAULT;
         a_nx = dss_pkg::AUTH_NONE;
      end else if (ev == dss_pkg::EV_FAULT) begin
         m_nx = dss_pkg::MODE_FAULT;
         a_nx = dss_pkg::AUTH_NONE;
         acc  = 1'b1;
      end else begin
         case (mode)
            dss_pkg::MODE_RESET_SAFE: begin
               if (ev == dss_pkg::EV_INIT_DONE) begin
                  m_nx = dss_pkg::MODE_DIAGNOSTIC;
                  a_nx = dss_pkg::AUTH_NONE;
                  acc  = 1'b1;
               end
            end
            dss_pkg::MODE_DIAGNOSTIC: begin
               if (ev == dss_pkg::EV_READY_LOST) begin
                  acc = 1'b1;
               end else if (ev == dss_pkg::EV_READY_OK && energize_ok) begin
                  m_nx = dss_pkg::MODE_READY;
                  a_nx = dss_pkg::AUTH_NONE;
                  acc  = 1'b1;
               end
            end
            dss_pkg::MODE_READY: begin
               if (ev == dss_pkg::EV_READY_LOST) begin
                  m_nx = dss_pkg::MODE_DIAGNOSTIC;
                  a_nx = dss_pkg::AUTH_NONE;
                  acc  = 1'b1;
               end else if (energize_ok) begin
                  case (ev)
                     dss_pkg::EV_DIAG_REQ: begin
                        m_nx = dss_pkg::MODE_RUN;
                        a_nx = dss_pkg::AUTH_DIAG;
                        acc  = 1'b1;
                     end
                     dss_pkg::EV_ALIGN_REQ: begin
                        m_nx = dss_pkg::MODE_ALIGN;
                        a_nx = dss_pkg::AUTH_MOTION;
                        acc  = 1'b1;
                     end
                     dss_pkg::EV_RUN_REQ: begin
                        m_nx = dss_pkg::MODE_RUN;
                        a_nx = dss_pkg::AUTH_MOTION;
                        acc  = 1'b1;
                     end
                     default: ;
                  endcase
               end
            end
            dss_pkg::MODE_ALIGN: begin
               if (ev == dss_pkg::EV_READY_LOST) begin
                  m_nx = dss_pkg::MODE_FAULT;
                  a_nx = dss_pkg::AUTH_NONE;
                  acc  = 1'b1;
               end else if (ev inside {dss_pkg::EV_ALIGN_DONE, dss_pkg::EV_RELEASE}) begin
                  m_nx = dss_pkg::MODE_READY;
                  a_nx = dss_pkg::AUTH_NONE;
                  acc  = 1'b1;
               end
            end
            dss_pkg::MODE_RUN: begin
               if (ev == dss_pkg::EV_READY_LOST) begin
                  m_nx = dss_pkg::MODE_FAULT;
                  a_nx = dss_pkg::AUTH_NONE;
                  acc  = 1'b1;
               end else if (ev == dss_pkg::EV_RELEASE) begin
                  m_nx = dss_pkg::MODE_READY;
                  a_nx = dss_pkg::AUTH_NONE;
                  acc  = 1'b1;
               end
            end
            dss_pkg::MODE_FAULT: begin
               if (ev == dss_pkg::EV_FAULT_ACK && recover_ok) begin
                  m_nx = dss_pkg::MODE_DIAGNOSTIC;
                  a_nx = dss_pkg::AUTH_NONE;
                  acc  = 1'b1;
               end
            end
            default: begin
               m_nx = dss_pkg::MODE_FAULT;
               a_nx = dss_pkg::AUTH_NONE;
            end
         endcase
      end
   end

   assign legal_nx = dss_pkg::pair_legal(m_nx, a_nx);

   always_comb begin
      step.accepted      = acc;
      step.mode_next     = m_nx;
      step.auth_next     = a_nx;
      step.bridge_enable = legal_nx &&
         ((m_nx == dss_pkg::MODE_ALIGN && a_nx == dss_pkg::AUTH_MOTION) ||
          (m_nx == dss_pkg::MODE_RUN &&
           (a_nx == dss_pkg::AUTH_DIAG || a_nx == dss_pkg::AUTH_MOTION)));
      step.foreground_allowed = legal_nx && (m_nx != dss_pkg::MODE_RESET_SAFE);
   end

endmodule

>>> hw/rtl/drive_safety_supervisor_fsm_core.sv
// Drive safety supervisor: input register, decision logic, result register.
// A transferred request is captured in the input register, decided combinationally and
// written to the result register, raising rsp_valid; a stall on rsp_ready can hold it in
// the input register. Throughput one transfer per cycle while rsp_ready does not stall.
// Reset (synchronous, active high): mode reset_safe, authority none, both stages empty.
// Depends on dss_pkg and dss_decide.
`timescale 1ns / 1ps

module drive_safety_supervisor_fsm_core (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [3:0] req_event_code,
   input  logic       req_energize_ok,
   input  logic       req_recover_ok,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_accepted,
   output logic [2:0] rsp_mode_now,
   output logic [1:0] rsp_authority_now,
   output logic       rsp_bridge_enable,
   output logic       rsp_foreground_allowed
);

   // Stage 1: captured request
   logic       s1_valid_ff, s1_valid_in;
   logic [3:0] s1_event_ff;
   logic       s1_energize_ff;
   logic       s1_recover_ff;

   // Supervisor state
   dss_pkg::mode_type mode_ff, mode_in;
   dss_pkg::auth_type auth_ff, auth_in;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   dss_pkg::step_type rsp_ff;

   dss_pkg::step_type step;
   logic              req_xfer;
   logic              rsp_free;   // result register can take a new value
   logic              s1_fire;    // stage 1 decides and commits this cycle

   // Handshake: the result register frees up when empty or being drained,
   // so one transfer per cycle flows through both stages while rsp_ready is not held low.
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && rsp_free;
   assign req_ready = !s1_valid_ff || rsp_free;
   assign req_xfer  = req_valid && req_ready;

   dss_decide u_decide (
      .mode        (mode_ff),
      .auth        (auth_ff),
      .event_code  (s1_event_ff),
      .energize_ok (s1_energize_ff),
      .recover_ok  (s1_recover_ff),
      .step        (step)
   );

   // Next state: mode/authority move only when a decision commits to the
   // result register, keeping state and response in lock step.
   always_comb begin
      s1_valid_in  = req_xfer ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
      rsp_valid_in = s1_fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      mode_in      = s1_fire ? step.mode_next : mode_ff;
      auth_in      = s1_fire ? step.auth_next : auth_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= dss_pkg::MODE_RESET_SAFE;
         auth_ff      <= dss_pkg::AUTH_NONE;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
         auth_ff      <= auth_in;
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_event_ff    <= req_event_code;
         s1_energize_ff <= req_energize_ok;
         s1_recover_ff  <= req_recover_ok;
      end
      if (s1_fire) begin
         rsp_ff <= step;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_accepted           = rsp_ff.accepted;
   assign rsp_mode_now           = 3'(rsp_ff.mode_next);
   assign rsp_authority_now      = 2'(rsp_ff.auth_next);
   assign rsp_bridge_enable      = rsp_ff.bridge_enable;
   assign rsp_foreground_allowed = rsp_ff.foreground_allowed;

`ifndef NO_ASSERTIONS
   // Stored mode/authority is always a legal pair.
   a_state_legal: assert property (@(posedge clock) disable iff (reset)
      dss_pkg::pair_legal(mode_ff, auth_ff))
      else $error("illegal mode/authority pair stored");

   // The held response reports the current stored state.
   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.mode_next == mode_ff && rsp_ff.auth_next == auth_ff))
      else $error("response out of step with supervisor state");

   // Bridge only energized in align or run.
   a_bridge_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.bridge_enable) |->
         (rsp_ff.mode_next == dss_pkg::MODE_ALIGN || rsp_ff.mode_next == dss_pkg::MODE_RUN))
      else $error("bridge enabled outside align/run");

   // State changes only on a committed decision.
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !s1_fire |=> ($stable(mode_ff) && $stable(auth_ff)))
      else $error("state moved without a decision");
`endif

endmodule

>>> dv/drive_safety_supervisor_fsm_core_tb.sv
// Testbench for drive_safety_supervisor_fsm_core: a scoreboard predicts each response
// from the accepted events, and a monitor compares every response field in order.
// Depends on dss_pkg and the supervisor core RTL.
`timescale 1ns / 1ps

module drive_safety_supervisor_fsm_core_tb;

   localparam int          CLK_HALF       = 5;
   localparam int          RESET_CYCLES   = 10;
   localparam int          RANDOM_EVENTS  = 1500;
   // Worst case: ~1530 transfers, each with the longest send gap, the longest
   // response stall and the pipe, plus one long hold-off. Taken ~4x.
   localparam int          CYCLE_LIMIT    = 600_000;
   localparam int          HOLD_AFTER     = 200;   // transfers before the long hold-off
   localparam int          HOLD_CYCLES    = 300;
   localparam int          DRAIN_CYCLES   = 8;     // pipe depth plus margin
   // Codes outside the defined event set.
   localparam logic [3:0]  EV_UNUSED_LOW  = 4'd10;
   localparam logic [3:0]  EV_UNUSED_HIGH = 4'd15;

   // ------------------------------------------------------------------
   // Scoreboard: own copy of mode and authority, queue of pending responses.
   // ------------------------------------------------------------------
   class supervisor_scoreboard;
      dss_pkg::mode_type mode;
      dss_pkg::auth_type grant;
      dss_pkg::step_type expected_q[$];
      int                errors;

      function new();
         mode   = dss_pkg::MODE_RESET_SAFE;
         grant  = dss_pkg::AUTH_NONE;
         errors = 0;
      endfunction

      // Pairs the supervisor may legally hold.
      function bit authority_fits(dss_pkg::mode_type m, dss_pkg::auth_type a);
         case (m)
            dss_pkg::MODE_RESET_SAFE, dss_pkg::MODE_DIAGNOSTIC,
            dss_pkg::MODE_READY, dss_pkg::MODE_FAULT: return a == dss_pkg::AUTH_NONE;
            dss_pkg::MODE_ALIGN: return a == dss_pkg::AUTH_MOTION;
            dss_pkg::MODE_RUN:
               return a == dss_pkg::AUTH_DIAG || a == dss_pkg::AUTH_MOTION;
            default:    return 1'b0;
         endcase
      endfunction

      function void move_to(dss_pkg::mode_type m, dss_pkg::auth_type a);
         mode  = m;
         grant = a;
      endfunction

      // Apply one event to the mode/authority pair; returns the verdict.
      function bit apply_event(logic [3:0] code, logic energize, logic recover);
         if (!authority_fits(mode, grant)) begin
            move_to(dss_pkg::MODE_FAULT, dss_pkg::AUTH_NONE);
            return 1'b0;
         end
         if (code == dss_pkg::EV_FAULT) begin
            move_to(dss_pkg::MODE_FAULT, dss_pkg::AUTH_NONE);
            return 1'b1;
         end
         case (mode)
            dss_pkg::MODE_RESET_SAFE: begin
               if (code == dss_pkg::EV_INIT_DONE) begin
                  move_to(dss_pkg::MODE_DIAGNOSTIC, dss_pkg::AUTH_NONE);
                  return 1'b1;
               end
            end
            dss_pkg::MODE_DIAGNOSTIC: begin
               if (code == dss_pkg::EV_READY_LOST) return 1'b1;
               if (code == dss_pkg::EV_READY_OK && energize) begin
                  move_to(dss_pkg::MODE_READY, dss_pkg::AUTH_NONE);
                  return 1'b1;
               end
            end
            dss_pkg::MODE_READY: begin
               if (code == dss_pkg::EV_READY_LOST) begin
                  move_to(dss_pkg::MODE_DIAGNOSTIC, dss_pkg::AUTH_NONE);
                  return 1'b1;
               end
               if (energize) begin
                  if (code == dss_pkg::EV_DIAG_REQ) begin
                     move_to(dss_pkg::MODE_RUN, dss_pkg::AUTH_DIAG);
                     return 1'b1;
                  end
                  if (code == dss_pkg::EV_ALIGN_REQ) begin
                     move_to(dss_pkg::MODE_ALIGN, dss_pkg::AUTH_MOTION);
                     return 1'b1;
                  end
                  if (code == dss_pkg::EV_RUN_REQ) begin
                     move_to(dss_pkg::MODE_RUN, dss_pkg::AUTH_MOTION);
                     return 1'b1;
                  end
               end
            end
            dss_pkg::MODE_ALIGN: begin
               if (code == dss_pkg::EV_READY_LOST) begin
                  move_to(dss_pkg::MODE_FAULT, dss_pkg::AUTH_NONE);
                  return 1'b1;
               end
               if (code == dss_pkg::EV_ALIGN_DONE || code == dss_pkg::EV_RELEASE) begin
                  move_to(dss_pkg::MODE_READY, dss_pkg::AUTH_NONE);
                  return 1'b1;
               end
            end
            dss_pkg::MODE_RUN: begin
               if (code == dss_pkg::EV_READY_LOST) begin
                  move_to(dss_pkg::MODE_FAULT, dss_pkg::AUTH_NONE);
                  return 1'b1;
               end
               if (code == dss_pkg::EV_RELEASE) begin
                  move_to(dss_pkg::MODE_READY, dss_pkg::AUTH_NONE);
                  return 1'b1;
               end
            end
            dss_pkg::MODE_FAULT: begin
               if (code == dss_pkg::EV_FAULT_ACK && recover) begin
                  move_to(dss_pkg::MODE_DIAGNOSTIC, dss_pkg::AUTH_NONE);
                  return 1'b1;
               end
            end
            default: move_to(dss_pkg::MODE_FAULT, dss_pkg::AUTH_NONE);
         endcase
         return 1'b0;
      endfunction

      // Called on every request transfer.
      function void note_event(logic [3:0] code, logic energize, logic recover);
         dss_pkg::step_type s;
         bit                legal;
         s.accepted           = apply_event(code, energize, recover);
         legal                = authority_fits(mode, grant);
         s.mode_next          = mode;
         s.auth_next          = grant;
         s.bridge_enable      = legal &&
            ((mode == dss_pkg::MODE_ALIGN && grant == dss_pkg::AUTH_MOTION) ||
             (mode == dss_pkg::MODE_RUN &&
              (grant == dss_pkg::AUTH_DIAG || grant == dss_pkg::AUTH_MOTION)));
         s.foreground_allowed = legal && mode != dss_pkg::MODE_RESET_SAFE;
         expected_q.push_back(s);
      endfunction

      function void compare_field(string name, int unsigned exp, logic [3:0] act);
         if (act !== exp[3:0]) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp, act);
            errors++;
         end
      endfunction

      // Called on every response transfer.
      function void check_result(logic acc, logic [2:0] m, logic [1:0] a, logic br,
                                 logic fg);
         dss_pkg::step_type s;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response, expected none, got mode %0d", $time, m);
            errors++;
            return;
         end
         s = expected_q.pop_front();
         compare_field("accepted", 32'(s.accepted), {3'b0, acc});
         compare_field("mode_now", 32'(s.mode_next), {1'b0, m});
         compare_field("authority_now", 32'(s.auth_next), {2'b0, a});
         compare_field("bridge_enable", 32'(s.bridge_enable), {3'b0, br});
         compare_field("foreground_allowed", 32'(s.foreground_allowed), {3'b0, fg});
      endfunction
   endclass

   // ------------------------------------------------------------------
   // DUT and signals
   // ------------------------------------------------------------------
   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [3:0] req_event_code;
   logic       req_energize_ok;
   logic       req_recover_ok;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_accepted;
   logic [2:0] rsp_mode_now;
   logic [1:0] rsp_authority_now;
   logic       rsp_bridge_enable;
   logic       rsp_foreground_allowed;

   drive_safety_supervisor_fsm_core dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_event_code         (req_event_code),
      .req_energize_ok        (req_energize_ok),
      .req_recover_ok         (req_recover_ok),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_accepted           (rsp_accepted),
      .rsp_mode_now           (rsp_mode_now),
      .rsp_authority_now      (rsp_authority_now),
      .rsp_bridge_enable      (rsp_bridge_enable),
      .rsp_foreground_allowed (rsp_foreground_allowed)
   );

   supervisor_scoreboard sb = new();

   int sent_count     = 0;
   int cycle_count    = 0;
   int send_burst     = 0;   // transfers left in a no-gap stretch, sender side
   int rcv_burst      = 0;   // cycles left in a no-stall stretch, receiver side
   bit hold_done      = 1'b0;

   initial clock = 1'b0;
   always #CLK_HALF clock = ~clock;

   // Hard stop: nothing correct comes close to this.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time, sb.expected_q.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Idle length: mostly none or short, a few long, with occasional
   // stretches where idling is switched off altogether.
   function automatic int pick_gap(inout int burst);
      int r;
      if (burst > 0) begin
         burst--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         burst = $urandom_range(30, 80);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------
   // Offer one event and hold it until the transfer; the scoreboard
   // sees it at the same edge. Valid stays high into the next event when
   // no gap follows, so it is never dropped and raised in one step.
   task automatic send_event(input logic [3:0] code, input logic energize, input logic recover);
      int gap;
      req_valid       <= 1'b1;
      req_event_code  <= code;
      req_energize_ok <= energize;
      req_recover_ok  <= recover;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_event(code, energize, recover);
      sent_count++;
      gap = pick_gap(send_burst);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Mostly events that make progress from the predicted mode, so the run
   // keeps cycling through ready, align, run and fault; the rest is noise.
   // The predicted mode already includes every event transferred so far.
   task automatic pick_random_event(output logic [3:0] code, output logic energize,
                                    output logic recover);
      int r;
      int k;
      r        = $urandom_range(0, 99);
      k        = $urandom_range(0, 3);
      energize = ($urandom_range(0, 99) < 85);
      recover  = ($urandom_range(0, 99) < 80);
      if (r < 78) begin
         case (sb.mode)
            dss_pkg::MODE_RESET_SAFE: code = dss_pkg::EV_INIT_DONE;
            dss_pkg::MODE_DIAGNOSTIC:
               code = (k == 0) ? dss_pkg::EV_READY_LOST : dss_pkg::EV_READY_OK;
            dss_pkg::MODE_READY: begin
               case (k)
                  0:       code = dss_pkg::EV_DIAG_REQ;
                  1:       code = dss_pkg::EV_ALIGN_REQ;
                  2:       code = dss_pkg::EV_RUN_REQ;
                  default: code = ($urandom_range(0, 2) == 0) ? dss_pkg::EV_READY_LOST
                                                              : dss_pkg::EV_RUN_REQ;
               endcase
            end
            dss_pkg::MODE_ALIGN: begin
               case (k)
                  0:       code = dss_pkg::EV_RELEASE;
                  1:       code = dss_pkg::EV_READY_LOST;
                  default: code = dss_pkg::EV_ALIGN_DONE;
               endcase
            end
            dss_pkg::MODE_RUN:
               code = (k == 0) ? dss_pkg::EV_READY_LOST : dss_pkg::EV_RELEASE;
            default:    code = dss_pkg::EV_FAULT_ACK;
         endcase
      end else if (r < 82) begin
         code = dss_pkg::EV_FAULT;
      end else begin
         code = 4'($urandom_range(0, 15));
      end
   endtask

   initial begin
      logic [3:0] code;
      logic       energize;
      logic       recover;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_event_code  = '0;
      req_energize_ok = 1'b0;
      req_recover_ok  = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed walk: undefined codes, rejected events, no-ops, each
      // request path, both exits from align and run, fault entry from
      // several modes and the acknowledge with and without recovery.
      send_event(EV_UNUSED_LOW, 1'b0, 1'b0);
      send_event(EV_UNUSED_HIGH, 1'b1, 1'b1);
      send_event(dss_pkg::EV_READY_OK, 1'b1, 1'b1);        // not in reset_safe
      send_event(dss_pkg::EV_INIT_DONE, 1'b0, 1'b0);
      send_event(dss_pkg::EV_READY_LOST, 1'b0, 1'b0);      // no-op in diagnostic
      send_event(dss_pkg::EV_READY_OK, 1'b0, 1'b1);        // needs energize
      send_event(dss_pkg::EV_READY_OK, 1'b1, 1'b0);
      send_event(dss_pkg::EV_DIAG_REQ, 1'b0, 1'b1);        // request without energize
      send_event(dss_pkg::EV_READY_LOST, 1'b0, 1'b0);      // back to diagnostic
      send_event(dss_pkg::EV_READY_OK, 1'b1, 1'b0);
      send_event(dss_pkg::EV_DIAG_REQ, 1'b1, 1'b0);        // run, diagnostic authority
      send_event(dss_pkg::EV_ALIGN_DONE, 1'b1, 1'b0);      // not in run
      send_event(dss_pkg::EV_RELEASE, 1'b1, 1'b0);
      send_event(dss_pkg::EV_ALIGN_REQ, 1'b1, 1'b0);
      send_event(dss_pkg::EV_ALIGN_DONE, 1'b0, 1'b0);
      send_event(dss_pkg::EV_ALIGN_REQ, 1'b1, 1'b1);
      send_event(dss_pkg::EV_RELEASE, 1'b0, 1'b0);
      send_event(dss_pkg::EV_RUN_REQ, 1'b1, 1'b0);         // run, motion authority
      send_event(dss_pkg::EV_READY_LOST, 1'b1, 1'b1);      // fault from run
      send_event(dss_pkg::EV_FAULT_ACK, 1'b1, 1'b0);       // recovery not allowed
      send_event(dss_pkg::EV_FAULT_ACK, 1'b0, 1'b1);
      send_event(dss_pkg::EV_FAULT, 1'b0, 1'b0);           // fault from diagnostic
      send_event(dss_pkg::EV_FAULT, 1'b1, 1'b1);           // fault while in fault
      send_event(dss_pkg::EV_FAULT_ACK, 1'b1, 1'b1);
      send_event(dss_pkg::EV_READY_OK, 1'b1, 1'b1);

      for (int i = 0; i < RANDOM_EVENTS; i++) begin
         pick_random_event(code, energize, recover);
         send_event(code, energize, recover);
      end
      req_valid <= 1'b0;

      // Drain, then let the pipe settle before judging.
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------
   // Random stalls, plus one long hold-off once traffic is flowing so the
   // pipe fills and req_ready drops while the sender keeps offering.
   initial begin
      int stall;
      rsp_ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && sent_count >= HOLD_AFTER) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            stall = pick_gap(rcv_burst);
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Monitor: every response transfer is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_result(rsp_accepted, rsp_mode_now, rsp_authority_now, rsp_bridge_enable,
                         rsp_foreground_allowed);
      end
   end

endmodule

>>> sim.f
hw/rtl/dss_pkg.sv
hw/rtl/dss_decide.sv
hw/rtl/drive_safety_supervisor_fsm_core.sv
dv/drive_safety_supervisor_fsm_core_tb.sv
